// ===== rtl/armenc_pkg.sv =====
// ----------------------------------------------------------------------------
// armenc_pkg
// Shared types, constants and the radix-64 alphabet for the armor encoder.
// ----------------------------------------------------------------------------
package armenc_pkg;

    localparam int          LINE_CHARS_DEF = 76;
    localparam int          QUEUE_DEPTH    = 4;
    localparam logic [23:0] CRC_INIT       = 24'hB704CE;
    localparam logic [23:0] CRC_POLY       = 24'h864CFB;

    localparam logic [7:0]  CHAR_NL        = 8'd10;
    localparam logic [7:0]  CHAR_PAD       = 8'd61;

    // character slots of one request, lowest emitted first
    localparam int          NUM_SLOTS      = 10;
    localparam logic [3:0]  SLOT_G0        = 4'd0;
    localparam logic [3:0]  SLOT_G1        = 4'd1;
    localparam logic [3:0]  SLOT_G2        = 4'd2;
    localparam logic [3:0]  SLOT_G3        = 4'd3;
    localparam logic [3:0]  SLOT_NL        = 4'd4;
    localparam logic [3:0]  SLOT_EQ        = 4'd5;
    localparam logic [3:0]  SLOT_C0        = 4'd6;
    localparam logic [3:0]  SLOT_C1        = 4'd7;
    localparam logic [3:0]  SLOT_C2        = 4'd8;
    localparam logic [3:0]  SLOT_C3        = 4'd9;

    typedef struct packed {
        logic        has_group;
        logic        pad2;
        logic        pad3;
        logic        newline;
        logic        has_crc;
        logic [23:0] group_val;
        logic [23:0] crc_val;
    } arm_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [NUM_SLOTS-1:0] job_mask(input arm_job_t j);
        return {{5{j.has_crc}}, j.newline, {4{j.has_group}}};
    endfunction

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) return w + 8'd65;
        else if (v < 6'd52) return w + 8'd71;
        else if (v < 6'd62) return w - 8'd4;
        else if (v == 6'd62) return 8'd43;
        else return 8'd47;
    endfunction

endpackage

// ===== rtl/armenc_front.sv =====
// ----------------------------------------------------------------------------
// armenc_front
// Takes bytes and finish commands, keeps CRC-24 and group state, and
// issues one character request per completed group or finish.
// ----------------------------------------------------------------------------
module armenc_front
    import armenc_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic       in_finish,
    input  logic [7:0] in_byte,
    input  q_status_t  q_status,
    output logic       in_ready,
    output logic       job_push,
    output arm_job_t   job
);

    localparam int GROUPS_PER_LINE = (LINE_CHARS + 3) / 4;
    localparam int GRP_W           = $clog2(GROUPS_PER_LINE + 1);

    logic [15:0]      gbytes_reg, gbytes_next;
    logic [1:0]       fill_reg, fill_next;
    logic [GRP_W-1:0] groups_reg, groups_next;
    logic [23:0]      crc_reg, crc_next;
    logic             lwn_reg, lwn_next;
    logic [GRP_W:0]   groups_inc;
    logic             line_full;
    logic             accept;

    function automatic logic [23:0] crc_byte(input logic [23:0] c, input logic [7:0] b);
        logic [23:0] r;
        r = c ^ {b, 16'h0000};
        for (int i = 0; i < 8; i++) begin
            r = r[23] ? ({r[22:0], 1'b0} ^ CRC_POLY) : {r[22:0], 1'b0};
        end
        return r;
    endfunction

    assign in_ready   = !q_status.full;
    assign accept     = in_valid && in_ready;
    assign groups_inc = {1'b0, groups_reg} + {{GRP_W{1'b0}}, 1'b1};
    assign line_full  = (groups_inc >= (GRP_W+1)'(GROUPS_PER_LINE));

    always_comb begin
        gbytes_next = gbytes_reg;
        fill_next   = fill_reg;
        groups_next = groups_reg;
        crc_next    = crc_reg;
        lwn_next    = lwn_reg;
        job_push    = 1'b0;
        job         = '0;
        job.crc_val = crc_reg;
        if (accept) begin
            if (in_finish) begin
                job_push      = 1'b1;
                job.has_group = (fill_reg != 2'd0);
                job.group_val = (fill_reg == 2'd1) ? {gbytes_reg[7:0], 16'h0000}
                                                   : {gbytes_reg, 8'h00};
                job.pad2      = (fill_reg == 2'd1);
                job.pad3      = (fill_reg != 2'd0);
                job.newline   = (fill_reg != 2'd0) || !lwn_reg;
                job.has_crc   = 1'b1;
                gbytes_next   = '0;
                fill_next     = '0;
                groups_next   = '0;
                crc_next      = CRC_INIT;
                lwn_next      = 1'b1;
            end else begin
                crc_next = crc_byte(crc_reg, in_byte);
                if (fill_reg < 2'd2) begin
                    gbytes_next = {gbytes_reg[7:0], in_byte};
                    fill_next   = fill_reg + 2'd1;
                end else begin
                    job_push      = 1'b1;
                    job.has_group = 1'b1;
                    job.group_val = {gbytes_reg, in_byte};
                    job.newline   = line_full;
                    gbytes_next   = '0;
                    fill_next     = '0;
                    groups_next   = line_full ? '0 : groups_inc[GRP_W-1:0];
                    lwn_next      = line_full;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gbytes_reg <= '0;
            fill_reg   <= '0;
            groups_reg <= '0;
            crc_reg    <= CRC_INIT;
            lwn_reg    <= 1'b1;
        end else begin
            gbytes_reg <= gbytes_next;
            fill_reg   <= fill_next;
            groups_reg <= groups_next;
            crc_reg    <= crc_next;
            lwn_reg    <= lwn_next;
        end
    end

endmodule

// ===== rtl/armenc_queue.sv =====
// ----------------------------------------------------------------------------
// armenc_queue
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module armenc_queue
    import armenc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  arm_job_t  din,
    input  logic      pop,
    output arm_job_t  dout,
    output q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    arm_job_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign dout         = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

// ===== rtl/armenc_back.sv =====
// ----------------------------------------------------------------------------
// armenc_back
// Walks the character slots of each request, one character per cycle while
// the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module armenc_back
    import armenc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  arm_job_t   q_dout,
    input  q_status_t  q_status,
    output logic       q_pop,
    output logic       out_valid,
    output logic [7:0] out_char,
    output logic       out_last,
    input  logic       out_ready
);

    arm_job_t             job_reg;
    logic                 busy_reg;
    logic [NUM_SLOTS-1:0] rem_reg, rem_after;
    logic                 out_valid_reg, out_last_reg;
    logic [7:0]           out_char_reg, ch;
    logic [3:0]           slot;
    logic                 out_free, advance, is_last;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

    always_comb begin
        slot = SLOT_G0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (rem_reg[i]) slot = 4'(i);
        end
    end

    assign rem_after = rem_reg & ~(NUM_SLOTS'(1) << slot);
    assign is_last   = (rem_after == '0);
    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = busy_reg && out_free;
    assign q_pop     = (!busy_reg || (advance && is_last)) && !q_status.empty;

    always_comb begin
        unique case (slot)
            SLOT_G0: ch = b64_char(job_reg.group_val[23:18]);
            SLOT_G1: ch = b64_char(job_reg.group_val[17:12]);
            SLOT_G2: ch = job_reg.pad2 ? CHAR_PAD : b64_char(job_reg.group_val[11:6]);
            SLOT_G3: ch = job_reg.pad3 ? CHAR_PAD : b64_char(job_reg.group_val[5:0]);
            SLOT_NL: ch = CHAR_NL;
            SLOT_EQ: ch = CHAR_PAD;
            SLOT_C0: ch = b64_char(job_reg.crc_val[23:18]);
            SLOT_C1: ch = b64_char(job_reg.crc_val[17:12]);
            SLOT_C2: ch = b64_char(job_reg.crc_val[11:6]);
            SLOT_C3: ch = b64_char(job_reg.crc_val[5:0]);
            default: ch = CHAR_PAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_dout;
        end
        if (advance) begin
            out_char_reg <= ch;
            out_last_reg <= is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                busy_reg <= 1'b1;
                rem_reg  <= job_mask(q_dout);
            end else if (advance && is_last) begin
                busy_reg <= 1'b0;
                rem_reg  <= '0;
            end else if (advance) begin
                rem_reg <= rem_after;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/radix64_crc24_armor_encoder.sv =====
// ----------------------------------------------------------------------------
// radix64_crc24_armor_encoder
// Radix-64 armor body encoder with CRC-24 trailer.
//
//   channel  port group           contents
//   input    s_tvalid/s_tready    s_tdata[7:0] data_byte, s_tuser cmd (1 = finish)
//   output   m_tvalid/m_tready    m_tdata[7:0] out_char, m_tlast run_last
//
// One input request is taken per cycle while the request queue has room.
// Output runs at one character per cycle while the output is not stalled: a
// group emits 4 or 5 characters, a finish 5 to 10.
// Reset is synchronous on aresetn low; control state returns to the blank-line
// start. Either side may stall; the queue and the output register part them.
// ----------------------------------------------------------------------------
module radix64_crc24_armor_encoder
    import armenc_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] cmd
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast
);

    arm_job_t  job, q_dout;
    logic      job_push, q_pop;
    q_status_t q_status;

    armenc_front #(
        .LINE_CHARS(LINE_CHARS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_finish(s_tuser),
        .in_byte  (s_tdata),
        .q_status (q_status),
        .in_ready (s_tready),
        .job_push (job_push),
        .job      (job)
    );

    armenc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (job_push),
        .din    (job),
        .pop    (q_pop),
        .dout   (q_dout),
        .status (q_status)
    );

    armenc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_dout   (q_dout),
        .q_status (q_status),
        .q_pop    (q_pop),
        .out_valid(m_tvalid),
        .out_char (m_tdata),
        .out_last (m_tlast),
        .out_ready(m_tready)
    );

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        job_push |-> !q_status.full)
        else $error("request pushed into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("request popped from empty queue");

    a_job_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (q_dout.has_group || q_dout.has_crc))
        else $error("request with no characters");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
